[hdl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// when cond holds at an edge, prop must hold at the same edge
`define TDSS_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("same-cycle implication violated");
// when cond holds at an edge, prop must hold at the next edge
`define TDSS_ASSERT_NXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("next-cycle implication violated");
`else
`define TDSS_ASSERT_IMP(lbl, clk, rst_n, cond, prop)
`define TDSS_ASSERT_NXT(lbl, clk, rst_n, cond, prop)
`endif

`endif

[hdl/tdss_pkg.sv]
// shared types and constants of the time of day speech sequencer
`default_nettype none
package tdss_pkg;

  typedef enum logic [1:0] {
    OpTick     = 2'd0,
    OpSetMin   = 2'd1,
    OpSetHour  = 2'd2,
    OpAnnounce = 2'd3
  } op_e;

  localparam int unsigned MaxTracks = 7;
  localparam int unsigned IdxW      = $clog2(MaxTracks);
  localparam int unsigned JobDepth  = 2;
  localparam int unsigned JobPtrW   = (JobDepth > 1) ? $clog2(JobDepth) : 1;
  localparam int unsigned JobCntW   = $clog2(JobDepth + 1);

  localparam logic [4:0] TrackTwenty  = 5'd21;
  localparam logic [4:0] TrackHour    = 5'd25;
  localparam logic [4:0] TrackMinutes = 5'd26;
  localparam logic [4:0] TrackClosing = 5'd27;

  // one classified event as handed from front to back
  typedef struct packed {
    logic                           is_announce;
    logic [4:0]                     hours;
    logic [5:0]                     minutes;
    logic [5:0]                     seconds;
    logic [MaxTracks-1:0][4:0]      tracks;
    logic [IdxW-1:0]                last_idx;
  } job_t;

  typedef struct packed {
    logic [4:0] spoken_track;
    logic       track_valid;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       last_of_run;
  } result_t;

endpackage
`default_nettype wire

[hdl/tdss_front.sv]
// front end: time counters, event classification and track list build
`default_nettype none
module tdss_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [1:0]    operation_i,
  input  wire logic [5:0]    seconds_elapsed_i,
  output tdss_pkg::job_t     job_o
);
  import tdss_pkg::*;

  logic [4:0] hour_q, hour_d;
  logic [5:0] min_q, min_d;
  logic [5:0] sec_q, sec_d;
  op_e        op;
  logic [5:0] add;
  logic [6:0] sec_sum;
  logic [5:0] min_inc;
  logic [4:0] hour_inc;
  logic       min_wrap;

  assign op       = op_e'(operation_i);
  assign add      = (seconds_elapsed_i > 6'd60) ? 6'd60 : seconds_elapsed_i;
  assign sec_sum  = {1'b0, sec_q} + {1'b0, add};
  assign min_wrap = (min_q == 6'd59);
  assign min_inc  = min_wrap ? 6'd0 : min_q + 6'd1;
  assign hour_inc = (hour_q == 5'd23) ? 5'd0 : hour_q + 5'd1;

  always_comb begin
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    if (accept_i) begin
      case (op)
        OpTick: begin
          if (sec_sum > 7'd59) begin
            sec_d = 6'(sec_sum - 7'd60);
            min_d = min_inc;
            if (min_wrap) hour_d = hour_inc;
          end else begin
            sec_d = sec_sum[5:0];
          end
        end
        OpSetMin:  min_d  = min_inc;
        OpSetHour: hour_d = hour_inc;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q <= '0;
      min_q  <= '0;
      sec_q  <= '0;
    end else begin
      hour_q <= hour_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
    end
  end

  // announce word list from the time as it stands before this event
  always_comb begin
    logic [IdxW-1:0] pos;
    logic [5:0]      tens_base;
    logic [4:0]      tens_word;
    logic [5:0]      ones;
    pos       = '0;
    tens_base = 6'd20;
    tens_word = 5'd21;
    ones      = '0;
    job_o             = '0;
    job_o.is_announce = (op == OpAnnounce);
    job_o.hours       = hour_d;
    job_o.minutes     = min_d;
    job_o.seconds     = sec_d;
    if (hour_q > 5'd20) begin
      job_o.tracks[pos] = TrackTwenty;
      pos = pos + 1'b1;
      job_o.tracks[pos] = hour_q - 5'd19;
    end else begin
      job_o.tracks[pos] = hour_q + 5'd1;
    end
    pos = pos + 1'b1;
    job_o.tracks[pos] = TrackHour;
    pos = pos + 1'b1;
    if (min_q < 6'd21) begin
      job_o.tracks[pos] = 5'(min_q + 6'd1);
    end else begin
      if (min_q >= 6'd50) begin
        tens_base = 6'd50;
        tens_word = 5'd24;
      end else if (min_q >= 6'd40) begin
        tens_base = 6'd40;
        tens_word = 5'd23;
      end else if (min_q >= 6'd30) begin
        tens_base = 6'd30;
        tens_word = 5'd22;
      end
      ones = min_q - tens_base;
      job_o.tracks[pos] = tens_word;
      // round tens past twenty are spoken as the tens word alone
      if (ones != 6'd0 || tens_base == 6'd20) begin
        pos = pos + 1'b1;
        job_o.tracks[pos] = 5'(ones + 6'd1);
      end
    end
    pos = pos + 1'b1;
    job_o.tracks[pos] = TrackMinutes;
    pos = pos + 1'b1;
    job_o.tracks[pos] = TrackClosing;
    job_o.last_idx = job_o.is_announce ? pos : '0;
  end
endmodule
`default_nettype wire

[hdl/tdss_job_queue.sv]
// short queue of classified events between front and back
`default_nettype none
`include "assert_macros.svh"
module tdss_job_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  tdss_pkg::job_t     job_i,
  input  wire logic          pop_i,
  output tdss_pkg::job_t     job_o,
  output logic               valid_o,
  output logic               full_o
);
  import tdss_pkg::*;

  job_t               slot_q [JobDepth];
  logic [JobPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [JobPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [JobCntW-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == JobCntW'(JobDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= job_i;
  end

  `TDSS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, count_q <= JobCntW'(JobDepth))
  `TDSS_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full_o, !push_i)
  `TDSS_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, do_pop && !do_push, count_q == $past(count_q) - 1'b1)
endmodule
`default_nettype wire

[hdl/tdss_back.sv]
// back end: steps through a job's results into the output register
`default_nettype none
`include "assert_macros.svh"
module tdss_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  tdss_pkg::job_t     job_i,
  input  wire logic          job_valid_i,
  output logic               job_pop_o,
  input  wire logic          res_pop_i,
  output logic               res_valid_o,
  output tdss_pkg::result_t  res_o
);
  import tdss_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  result_t         res_q, res_d;
  logic            load;
  logic            is_last;

  assign load      = job_valid_i && (!out_valid_q || res_pop_i);
  assign is_last   = (idx_q == job_i.last_idx);
  assign job_pop_o = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (res_pop_i && out_valid_q) out_valid_d = 1'b0;
    if (load) begin
      out_valid_d        = 1'b1;
      res_d.spoken_track = job_i.is_announce ? job_i.tracks[idx_q] : 5'd0;
      res_d.track_valid  = job_i.is_announce;
      res_d.hours        = job_i.hours;
      res_d.minutes      = job_i.minutes;
      res_d.seconds      = job_i.seconds;
      res_d.last_of_run  = is_last;
      idx_d              = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  `TDSS_ASSERT_IMP(a_mid_run_has_job, clk_i, rst_ni, idx_q != '0, job_valid_i)
  `TDSS_ASSERT_IMP(a_idx_bound, clk_i, rst_ni, 1'b1, idx_q <= IdxW'(MaxTracks - 1))
  `TDSS_ASSERT_IMP(a_plain_is_last, clk_i, rst_ni, out_valid_q && !res_q.track_valid, res_q.last_of_run)
endmodule
`default_nettype wire

[hdl/time_of_day_speech_sequencer_unit.sv]
// top level of the time of day speech sequencer
`default_nettype none
// Keeps a 24-hour clock (hour, minute, second) and speaks it on request.
// Items enter through a queue-style port (push/full) and results leave
// through another (empty/pop). Operation 0 adds seconds_elapsed (clamped to
// 60) with carry into minute and hour, 1 and 2 bump the minute or hour with
// wrap and no carry; each gives one beat with the new time and track_valid
// low. Operation 3 leaves the time alone and gives five to seven beats of
// track numbers (hour words, 25, minute words, 26, 27) with last_of_run high
// on the final one. The front end updates the counters and builds the word
// list in the cycle an item is accepted, so a push is taken every cycle
// while the two-entry job queue has room. The back end emits one result beat
// per cycle from the queue head into an output register while that register
// is empty or being popped. An accepted item is written into the job queue
// and its first result then into the output register, from which it can be
// popped. No clearing pass after reset: the block is ready at once.
module time_of_day_speech_sequencer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input side
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] operation_i,
  input  wire logic [5:0] seconds_elapsed_i,
  // result side
  output logic            empty,
  input  wire logic       pop,
  output logic [4:0]      spoken_track_o,
  output logic            track_valid_o,
  output logic [4:0]      hours_now_o,
  output logic [5:0]      minutes_now_o,
  output logic [5:0]      seconds_now_o,
  output logic            last_of_run_o
);
  import tdss_pkg::*;

  job_t    front_job;
  job_t    head_job;
  logic    accept;
  logic    head_valid;
  logic    head_pop;
  logic    res_valid;
  result_t res;

  // an item beat is taken whenever the job queue has a free slot
  assign accept = push && !full;

  tdss_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .operation_i       (operation_i),
    .seconds_elapsed_i (seconds_elapsed_i),
    .job_o             (front_job)
  );

  // decouples counter update from result streaming
  tdss_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .job_i   (front_job),
    .pop_i   (head_pop),
    .job_o   (head_job),
    .valid_o (head_valid),
    .full_o  (full)
  );

  tdss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (head_valid),
    .job_pop_o   (head_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty          = !res_valid;
  assign spoken_track_o = res.spoken_track;
  assign track_valid_o  = res.track_valid;
  assign hours_now_o    = res.hours;
  assign minutes_now_o  = res.minutes;
  assign seconds_now_o  = res.seconds;
  assign last_of_run_o  = res.last_of_run;
endmodule
`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the time of day speech sequencer unit
`timescale 1ns / 1ps

module tb_top;
  import tdss_pkg::*;

  // one row of the directed part; typed rows carry the time read off by hand
  typedef struct packed {
    op_e        op;
    logic [5:0] secs;
    logic       typed;
    logic [4:0] hh;
    logic [5:0] mm;
    logic [5:0] ss;
  } stim_row_t;

  localparam int NumDirRows = 20;
  localparam stim_row_t DirRows [NumDirRows] = '{
    '{OpTick,     6'd0,  1'b1, 5'd0, 6'd0, 6'd0},   // zero seconds, nothing moves
    '{OpAnnounce, 6'd63, 1'b0, 5'd0, 6'd0, 6'd0},   // midnight
    '{OpTick,     6'd63, 1'b1, 5'd0, 6'd1, 6'd0},   // clamped to 60
    '{OpTick,     6'd61, 1'b1, 5'd0, 6'd2, 6'd0},
    '{OpTick,     6'd59, 1'b1, 5'd0, 6'd2, 6'd59},
    '{OpTick,     6'd1,  1'b1, 5'd0, 6'd3, 6'd0},   // carry by one second
    '{OpTick,     6'd62, 1'b1, 5'd0, 6'd4, 6'd0},
    '{OpSetMin,   6'd63, 1'b1, 5'd0, 6'd5, 6'd0},   // seconds ignored on a press
    '{OpSetHour,  6'd42, 1'b1, 5'd1, 6'd5, 6'd0},
    '{OpAnnounce, 6'd0,  1'b0, 5'd0, 6'd0, 6'd0},
    '{OpTick,     6'd60, 1'b1, 5'd1, 6'd6, 6'd0},
    '{OpTick,     6'd37, 1'b1, 5'd1, 6'd6, 6'd37},
    '{OpTick,     6'd23, 1'b1, 5'd1, 6'd7, 6'd0},
    '{OpSetHour,  6'd0,  1'b1, 5'd2, 6'd7, 6'd0},
    '{OpAnnounce, 6'd21, 1'b0, 5'd0, 6'd0, 6'd0},
    '{OpTick,     6'd45, 1'b1, 5'd2, 6'd7, 6'd45},
    '{OpTick,     6'd30, 1'b1, 5'd2, 6'd8, 6'd15},
    '{OpSetMin,   6'd7,  1'b1, 5'd2, 6'd9, 6'd15},
    '{OpAnnounce, 6'd42, 1'b0, 5'd0, 6'd0, 6'd0},
    '{OpTick,     6'd0,  1'b1, 5'd2, 6'd9, 6'd15}
  };

  // times the random walks steer to before announcing: tens words and edges
  localparam int NumMinStops  = 14;
  localparam int NumHourStops = 6;
  localparam logic [5:0] MinuteStops [NumMinStops] = '{
    6'd20, 6'd21, 6'd29, 6'd30, 6'd31, 6'd39, 6'd40,
    6'd41, 6'd49, 6'd50, 6'd51, 6'd59, 6'd0, 6'd10
  };
  localparam logic [4:0] HourStops [NumHourStops] = '{
    5'd20, 5'd21, 5'd22, 5'd23, 5'd0, 5'd12
  };

  localparam int RandomItems = 300;
  localparam int HoldCycles  = 150;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] operation_i = 2'd0;
  logic [5:0] seconds_elapsed_i = 6'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [4:0] spoken_track_o;
  logic       track_valid_o;
  logic [4:0] hours_now_o;
  logic [5:0] minutes_now_o;
  logic [5:0] seconds_now_o;
  logic       last_of_run_o;

  time_of_day_speech_sequencer_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .operation_i       (operation_i),
    .seconds_elapsed_i (seconds_elapsed_i),
    .empty             (empty),
    .pop               (pop),
    .spoken_track_o    (spoken_track_o),
    .track_valid_o     (track_valid_o),
    .hours_now_o       (hours_now_o),
    .minutes_now_o     (minutes_now_o),
    .seconds_now_o     (seconds_now_o),
    .last_of_run_o     (last_of_run_o)
  );

  // predicted time of day, updated as each item is accepted
  logic [4:0] tod_hour = 5'd0;
  logic [5:0] tod_min  = 6'd0;
  logic [5:0] tod_sec  = 6'd0;

  // beats the block still owes us, oldest first
  result_t beats_due [$];

  int unsigned items_sent     = 0;
  int unsigned announces_sent = 0;
  int unsigned beats_checked  = 0;
  int unsigned bad_beats      = 0;
  int unsigned full_stalls    = 0;
  int unsigned burst_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // tick, set-minute and set-hour effect on the clock
  function automatic void tod_advance(op_e op, logic [5:0] secs);
    int unsigned sum;
    case (op)
      OpTick: begin
        sum = tod_sec + ((secs > 6'd60) ? 6'd60 : secs);
        if (sum > 59) begin
          sum = sum - 60;
          if (tod_min == 6'd59) begin
            tod_min  = 6'd0;
            tod_hour = (tod_hour == 5'd23) ? 5'd0 : tod_hour + 5'd1;
          end else begin
            tod_min = tod_min + 6'd1;
          end
        end
        tod_sec = 6'(sum);
      end
      OpSetMin:  tod_min  = (tod_min == 6'd59) ? 6'd0 : tod_min + 6'd1;
      OpSetHour: tod_hour = (tod_hour == 5'd23) ? 5'd0 : tod_hour + 5'd1;
      default: ;
    endcase
  endfunction

  // words of the current time: hour words, hour word, minute words, minutes word, closing
  function automatic void speak_time();
    logic [4:0]  words [7];
    int unsigned n;
    int unsigned tens;
    result_t     beat;
    n = 0;
    if (tod_hour > 5'd20) begin
      words[n++] = TrackTwenty;
      words[n++] = 5'(tod_hour - 19);
    end else begin
      words[n++] = 5'(tod_hour + 1);
    end
    words[n++] = TrackHour;
    if (tod_min < 6'd21) begin
      words[n++] = 5'(tod_min + 1);
    end else begin
      tens = tod_min / 10;
      words[n++] = 5'(19 + tens);
      // the round tens past twenty speak the tens word alone
      if ((tod_min % 10) != 0 || tens == 2) words[n++] = 5'(tod_min - (tens * 10 - 1));
    end
    words[n++] = TrackMinutes;
    words[n++] = TrackClosing;
    for (int unsigned k = 0; k < n; k++) begin
      beat.spoken_track = words[k];
      beat.track_valid  = 1'b1;
      beat.hours        = tod_hour;
      beat.minutes      = tod_min;
      beat.seconds      = tod_sec;
      beat.last_of_run  = (k == n - 1);
      beats_due.push_back(beat);
    end
  endfunction

  function automatic void predict_item(op_e op, logic [5:0] secs);
    if (op == OpAnnounce) begin
      speak_time();
    end else begin
      tod_advance(op, secs);
      beats_due.push_back('{5'd0, 1'b0, tod_hour, tod_min, tod_sec, 1'b1});
    end
  endfunction

  // hold one beat on the input until the block takes it; push stays high
  task automatic offer_item(op_e op, logic [5:0] secs);
    push              <= 1'b1;
    operation_i       <= op;
    seconds_elapsed_i <= secs;
    forever begin
      @(posedge clk_i);
      if (!full) break;
      full_stalls++;
    end
    items_sent++;
    if (op == OpAnnounce) announces_sent++;
  endtask

  // sender bursts: after a burst, drop push for a random gap
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // stop offering until every owed beat is back, plus a few spare cycles
  task automatic drain_results();
    push <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [5:0] random_secs();
    case ($urandom_range(0, 3))
      0: return 6'($urandom_range(0, 63));
      1: return 6'($urandom_range(60, 63));
      2: return 6'($urandom_range(0, 2));
      default: return 6'($urandom_range(0, 60));
    endcase
  endfunction

  // stimulus side
  initial begin
    int unsigned random_sent;
    int unsigned walks;
    int unsigned noise_len;
    bit          mid_drain_done;
    logic [5:0]  min_goal;
    logic [4:0]  hour_goal;
    op_e         op;
    random_sent    = 0;
    walks          = 0;
    mid_drain_done = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: typed rows carry their own expected time
    for (int i = 0; i < NumDirRows; i++) begin
      offer_item(DirRows[i].op, DirRows[i].secs);
      if (DirRows[i].typed) begin
        tod_advance(DirRows[i].op, DirRows[i].secs);
        beats_due.push_back('{5'd0, 1'b0, DirRows[i].hh, DirRows[i].mm, DirRows[i].ss, 1'b1});
      end else begin
        predict_item(DirRows[i].op, DirRows[i].secs);
      end
      pace_sender();
    end
    drain_results();

    // random part: mostly walks to a chosen time then an announce, plus noise
    while (random_sent < RandomItems) begin
      if ($urandom_range(0, 2) != 0) begin
        if (walks % 3 == 2) begin
          hour_goal = HourStops[(walks / 3) % NumHourStops];
          while (tod_hour != hour_goal) begin
            offer_item(OpSetHour, random_secs());
            predict_item(OpSetHour, seconds_elapsed_i);
            random_sent++;
            pace_sender();
          end
        end else begin
          min_goal = MinuteStops[(walks - walks / 3) % NumMinStops];
          // a full-minute tick steps the minute just like a press
          while (tod_min != min_goal) begin
            op = ($urandom_range(0, 3) == 0) ? OpTick : OpSetMin;
            offer_item(op, (op == OpTick) ? 6'($urandom_range(60, 63)) : random_secs());
            predict_item(op, seconds_elapsed_i);
            random_sent++;
            pace_sender();
          end
        end
        walks++;
        offer_item(OpAnnounce, random_secs());
        predict_item(OpAnnounce, seconds_elapsed_i);
        random_sent++;
        pace_sender();
      end else begin
        noise_len = $urandom_range(1, 6);
        repeat (noise_len) begin
          op = op_e'($urandom_range(0, 3));
          offer_item(op, random_secs());
          predict_item(op, seconds_elapsed_i);
          random_sent++;
          pace_sender();
        end
      end
      if (!mid_drain_done && random_sent >= RandomItems / 2) begin
        mid_drain_done = 1;
        drain_results();
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    $display("covered %0d items (%0d announces, %0d walks) and %0d result beats",
             items_sent, announces_sent, walks, beats_checked);
    $display("input held off by full on %0d cycles", full_stalls);
    if (bad_beats == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: check every accepted beat, stall on a pattern of our own
  initial begin
    result_t     got;
    result_t     want;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned holds_done;
    int unsigned next_hold;
    int unsigned phase;
    mode       = 0;
    mode_left  = 0;
    holds_done = 0;
    next_hold  = 60;
    phase      = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = '{spoken_track_o, track_valid_o, hours_now_o, minutes_now_o,
                seconds_now_o, last_of_run_o};
        if (beats_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("stray beat: track %0d valid %0b %0d:%0d:%0d last %0b",
                     got.spoken_track, got.track_valid, got.hours, got.minutes,
                     got.seconds, got.last_of_run);
        end else begin
          want = beats_due.pop_front();
          beats_checked++;
          if (got != want) begin
            bad_beats++;
            if (bad_beats <= 10) begin
              $display("mismatch at beat %0d: want track %0d valid %0b %0d:%0d:%0d last %0b",
                       beats_checked, want.spoken_track, want.track_valid, want.hours,
                       want.minutes, want.seconds, want.last_of_run);
              $display("  got track %0d valid %0b %0d:%0d:%0d last %0b",
                       got.spoken_track, got.track_valid, got.hours, got.minutes,
                       got.seconds, got.last_of_run);
            end
          end
        end
      end
      if (holds_done < 2 && beats_checked >= next_hold) begin
        // long hold-off so the block fills up and raises full
        holds_done++;
        next_hold = 250;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ((phase % 7) < 4);
        endcase
      end
    end
  end

  // hard limit well above the slowest correct run
  initial begin
    #400_000;
    $display("timeout with %0d beats still owed", beats_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/tdss_pkg.sv
hdl/tdss_front.sv
hdl/tdss_job_queue.sv
hdl/tdss_back.sv
hdl/time_of_day_speech_sequencer_unit.sv
tb/tb_top.sv
